// ----- design/vm86e_pkg.sv -----
package vm86e_pkg;

   // Opcodes and prefixes
   localparam logic [7:0] OPC_OPSIZE = 8'h66;
   localparam logic [7:0] OPC_ADSIZE = 8'h67;
   localparam logic [7:0] OPC_INT    = 8'hCD;
   localparam logic [7:0] OPC_PUSHF  = 8'h9C;
   localparam logic [7:0] OPC_POPF   = 8'h9D;
   localparam logic [7:0] OPC_OUTB   = 8'hEE;
   localparam logic [7:0] OPC_OUTW   = 8'hEF;
   localparam logic [7:0] OPC_INB    = 8'hEC;
   localparam logic [7:0] OPC_INW    = 8'hED;
   localparam logic [7:0] OPC_IRET   = 8'hCF;
   localparam logic [7:0] OPC_CLI    = 8'hFA;
   localparam logic [7:0] OPC_STI    = 8'hFB;

   // Interrupt vectors with special meaning
   localparam logic [7:0] VEC_EXIT = 8'h03;
   localparam logic [7:0] VEC_WAIT = 8'hFC;

   // Flag bits
   localparam int unsigned FLAG_IF_BIT = 9;
   localparam logic [31:0] FLAG_IF = 32'h0000_0200;
   localparam logic [31:0] FLAG_VM = 32'h0002_0000;

   // Status codes
   localparam logic [1:0] ST_RESUME    = 2'd0;
   localparam logic [1:0] ST_EXIT      = 2'd1;
   localparam logic [1:0] ST_WAIT      = 2'd2;
   localparam logic [1:0] ST_UNHANDLED = 2'd3;

   // Side item kinds
   localparam logic [3:0] SK_FINAL = 4'd0;
   localparam logic [3:0] SK_OUT8  = 4'd1;
   localparam logic [3:0] SK_OUT16 = 4'd2;
   localparam logic [3:0] SK_OUT32 = 4'd3;
   localparam logic [3:0] SK_IN8   = 4'd4;
   localparam logic [3:0] SK_IN16  = 4'd5;
   localparam logic [3:0] SK_IN32  = 4'd6;
   localparam logic [3:0] SK_MEM16 = 4'd7;
   localparam logic [3:0] SK_MEM32 = 4'd8;

   localparam int unsigned NUM_SIDES = 3;

   typedef struct packed {
      logic [31:0] insn_bytes;
      logic [15:0] guest_ip;
      logic [15:0] guest_cs;
      logic [15:0] guest_ss;
      logic [15:0] guest_sp;
      logic [31:0] guest_flags;
      logic [31:0] guest_acc;
      logic [15:0] guest_port;
      logic [31:0] port_read_data;
      logic [31:0] mem_word0;
      logic [31:0] mem_word1;
      logic [31:0] mem_word2;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  side_kind;
      logic [20:0] side_addr;
      logic [31:0] side_data;
      logic [15:0] new_ip;
      logic [15:0] new_cs;
      logic [15:0] new_sp;
      logic [31:0] new_flags;
      logic [31:0] new_acc;
      logic        last;
   } rsp_type;

   // One side item; patch_if puts the virtual IF into data bit 9
   typedef struct packed {
      logic [3:0]  kind;
      logic [20:0] addr;
      logic [31:0] data;
      logic        patch_if;
   } side_type;

   // Decoded trap handed from the front end to the back end
   typedef struct packed {
      side_type [NUM_SIDES-1:0] sides;
      logic [1:0]  nside;
      logic [1:0]  status;
      logic [15:0] new_ip;
      logic [15:0] new_cs;
      logic [15:0] new_sp;
      logic [31:0] new_flags;
      logic [31:0] new_acc;
      logic        vif_wr;
      logic        vif_val;
   } job_type;

endpackage

// ----- design/vm86_sensitive_insn_emulator_core.sv -----
// A request is queued at acceptance; its first result then comes from the back end's
// output register, one result per cycle while rsp_ready holds, so a trap
// yields one result (final only) to four (three stack writes and the final).
// The front end decodes one request per cycle into a two-entry queue while it has room.
// Reset (synchronous, active high) clears the virtual IF, the queue and output valid.
module vm86_sensitive_insn_emulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vm86e_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vm86e_pkg::rsp_type rsp_payload
);
   import vm86e_pkg::*;

   job_type dec_job;
   job_type q_job;
   logic    q_valid;
   logic    q_ready;

   // Decode
   vm86e_front u_front (
      .req (req_payload),
      .job (dec_job)
   );

   // Decoupling queue
   vm86e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (dec_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_job)
   );

   // Execute and emit results
   vm86e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_valid),
      .job_ready   (q_ready),
      .job         (q_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- design/vm86e_front.sv -----
module vm86e_front (
   input  vm86e_pkg::req_type req,
   output vm86e_pkg::job_type job
);
   import vm86e_pkg::*;

   function automatic logic [20:0] lin_addr(input logic [15:0] seg, input logic [15:0] off);
      lin_addr = {1'b0, seg, 4'b0000} + {5'b0_0000, off};
   endfunction

   logic [7:0]  byt [4];
   logic [2:0]  pos;
   logic        d32;
   logic        found;
   logic [7:0]  op;
   logic [7:0]  vec;
   logic [15:0] ip_p;
   logic [15:0] sp_int;
   logic [15:0] sp_push;
   logic [31:0] popped;

   // Prefix scan: find the first byte that is not a prefix
   always_comb begin
      pos   = 3'd4;
      d32   = 1'b0;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         byt[i] = req.insn_bytes[8*i +: 8];
         if (!found) begin
            if (byt[i] == OPC_OPSIZE) begin
               d32 = 1'b1;
            end else if (byt[i] != OPC_ADSIZE) begin
               found = 1'b1;
               pos   = 3'(i);
            end
         end
      end
   end

   assign ip_p    = req.guest_ip + {13'd0, pos};
   assign op      = byt[pos[1:0]];
   assign vec     = byt[pos[1:0] + 2'd1];
   assign sp_int  = req.guest_sp - 16'd6;
   assign sp_push = req.guest_sp - (d32 ? 16'd4 : 16'd2);

   // Instruction decode into side items and final registers
   always_comb begin
      job           = '0;
      job.status    = ST_UNHANDLED;
      job.new_ip    = ip_p;
      job.new_cs    = req.guest_cs;
      job.new_sp    = req.guest_sp;
      job.new_flags = req.guest_flags;
      job.new_acc   = req.guest_acc;
      popped        = '0;
      if (!pos[2]) begin
         case (op)
            OPC_INT: begin
               if (pos != 3'd3) begin
                  if (vec == VEC_EXIT) begin
                     job.status = ST_EXIT;
                  end else if (vec == VEC_WAIT) begin
                     job.status = ST_WAIT;
                     job.new_ip = ip_p + 16'd2;
                  end else begin
                     job.status         = ST_RESUME;
                     job.nside          = 2'd3;
                     job.sides[0].kind  = SK_MEM16;
                     job.sides[0].addr  = lin_addr(req.guest_ss, sp_int);
                     job.sides[0].data  = {16'd0, ip_p + 16'd2};
                     job.sides[1].kind  = SK_MEM16;
                     job.sides[1].addr  = lin_addr(req.guest_ss, sp_int + 16'd2);
                     job.sides[1].data  = {16'd0, req.guest_cs};
                     job.sides[2].kind  = SK_MEM16;
                     job.sides[2].addr  = lin_addr(req.guest_ss, sp_int + 16'd4);
                     job.sides[2].data  = {16'd0, req.guest_flags[15:0]};
                     job.sides[2].patch_if = 1'b1;
                     job.new_ip         = req.mem_word0[15:0];
                     job.new_cs         = req.mem_word0[31:16];
                     job.new_sp         = sp_int;
                  end
               end
            end
            OPC_PUSHF: begin
               job.status            = ST_RESUME;
               job.nside             = 2'd1;
               job.sides[0].kind     = d32 ? SK_MEM32 : SK_MEM16;
               job.sides[0].addr     = lin_addr(req.guest_ss, sp_push);
               job.sides[0].data     = d32 ? req.guest_flags
                                           : {16'd0, req.guest_flags[15:0]};
               job.sides[0].patch_if = 1'b1;
               job.new_sp            = sp_push;
               job.new_ip            = ip_p + 16'd1;
            end
            OPC_POPF: begin
               popped        = d32 ? req.mem_word0 : {16'd0, req.mem_word0[15:0]};
               job.status    = ST_RESUME;
               job.new_flags = popped | FLAG_VM | FLAG_IF;
               job.vif_wr    = 1'b1;
               job.vif_val   = popped[FLAG_IF_BIT];
               job.new_sp    = req.guest_sp + (d32 ? 16'd4 : 16'd2);
               job.new_ip    = ip_p + 16'd1;
            end
            OPC_OUTB: begin
               job.status        = ST_RESUME;
               job.nside         = 2'd1;
               job.sides[0].kind = SK_OUT8;
               job.sides[0].addr = {5'd0, req.guest_port};
               job.sides[0].data = {24'd0, req.guest_acc[7:0]};
               job.new_ip        = ip_p + 16'd1;
            end
            OPC_OUTW: begin
               job.status        = ST_RESUME;
               job.nside         = 2'd1;
               job.sides[0].kind = d32 ? SK_OUT32 : SK_OUT16;
               job.sides[0].addr = {5'd0, req.guest_port};
               job.sides[0].data = d32 ? req.guest_acc : {16'd0, req.guest_acc[15:0]};
               job.new_ip        = ip_p + 16'd1;
            end
            OPC_INB: begin
               job.status        = ST_RESUME;
               job.nside         = 2'd1;
               job.sides[0].kind = SK_IN8;
               job.sides[0].addr = {5'd0, req.guest_port};
               job.new_acc       = {req.guest_acc[31:8], req.port_read_data[7:0]};
               job.new_ip        = ip_p + 16'd1;
            end
            OPC_INW: begin
               job.status        = ST_RESUME;
               job.nside         = 2'd1;
               job.sides[0].kind = d32 ? SK_IN32 : SK_IN16;
               job.sides[0].addr = {5'd0, req.guest_port};
               job.new_acc       = d32 ? req.port_read_data
                                       : {req.guest_acc[31:16], req.port_read_data[15:0]};
               job.new_ip        = ip_p + 16'd1;
            end
            OPC_IRET: begin
               popped        = d32 ? req.mem_word2 : {16'd0, req.mem_word2[15:0]};
               job.status    = ST_RESUME;
               job.new_ip    = req.mem_word0[15:0];
               job.new_cs    = req.mem_word1[15:0];
               job.new_flags = popped | FLAG_VM | FLAG_IF;
               job.vif_wr    = 1'b1;
               job.vif_val   = popped[FLAG_IF_BIT];
               job.new_sp    = req.guest_sp + (d32 ? 16'd12 : 16'd6);
            end
            OPC_CLI: begin
               job.status  = ST_RESUME;
               job.vif_wr  = 1'b1;
               job.vif_val = 1'b0;
               job.new_ip  = ip_p + 16'd1;
            end
            OPC_STI: begin
               job.status  = ST_RESUME;
               job.vif_wr  = 1'b1;
               job.vif_val = 1'b1;
               job.new_ip  = ip_p + 16'd1;
            end
            default: begin
               job.status = ST_UNHANDLED;
            end
         endcase
      end
   end

endmodule

// ----- design/vm86e_queue.sv -----
module vm86e_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  vm86e_pkg::job_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output vm86e_pkg::job_type pop_data
);
   import vm86e_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptrs_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> rd_ptr_ff != $past(rd_ptr_ff))
      else $error("read pointer did not advance");

endmodule

// ----- design/vm86e_back.sv -----
module vm86e_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  vm86e_pkg::job_type job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vm86e_pkg::rsp_type rsp_payload
);
   import vm86e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       vif_ff, vif_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       is_side;
   side_type   cur_side;

   assign load      = job_valid && (!rsp_valid_ff || rsp_ready);
   assign is_side   = idx_ff < job.nside;
   assign job_ready = load && !is_side;

   // Select the side item for this step
   always_comb begin
      case (idx_ff)
         2'd0:    cur_side = job.sides[0];
         2'd1:    cur_side = job.sides[1];
         2'd2:    cur_side = job.sides[2];
         default: cur_side = job.sides[0];
      endcase
   end

   // Build the next request on the result channel
   always_comb begin
      rsp_in = '0;
      if (is_side) begin
         rsp_in.side_kind = cur_side.kind;
         rsp_in.side_addr = cur_side.addr;
         rsp_in.side_data = cur_side.data;
         if (cur_side.patch_if) begin
            rsp_in.side_data[FLAG_IF_BIT] = vif_ff;
         end
      end else begin
         rsp_in.status    = job.status;
         rsp_in.side_kind = SK_FINAL;
         rsp_in.new_ip    = job.new_ip;
         rsp_in.new_cs    = job.new_cs;
         rsp_in.new_sp    = job.new_sp;
         rsp_in.new_flags = job.new_flags;
         rsp_in.new_acc   = job.new_acc;
         rsp_in.last      = 1'b1;
      end
   end

   // Step counter, virtual IF and output valid
   always_comb begin
      idx_in       = idx_ff;
      vif_in       = vif_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (is_side) begin
            idx_in = idx_ff + 2'd1;
         end else begin
            idx_in = 2'd0;
            if (job.vif_wr) begin
               vif_in = job.vif_val;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         vif_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         vif_ff       <= vif_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_final_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> rsp_ff.side_kind == SK_FINAL && rsp_ff.side_data == '0)
      else $error("final request carries side fields");

   a_side_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |->
         rsp_ff.side_kind != SK_FINAL && rsp_ff.status == ST_RESUME)
      else $error("side request malformed");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> idx_ff <= job.nside)
      else $error("step counter ran past side count");

   a_step_reset: assert property (@(posedge clock) disable iff (reset)
      job_ready |=> idx_ff == 2'd0)
      else $error("step counter not cleared after final");

endmodule

// ----- tb/vm86_sensitive_insn_emulator_core_tb.sv -----
module vm86_sensitive_insn_emulator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vm86e_pkg::*;

   typedef struct {
      req_type req;
      bit      wait_idle;   // hold this request back until every result is in
   } queued_trap_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_EVERY_FOURTH_LOW,
      RDY_SPARSE
   } ready_mode_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   queued_trap_type pending_traps[$];
   rsp_type         expected_results[$];
   logic            model_vif;
   int              traps_total;
   int              traps_sent;
   int              error_count;

   vm86_sensitive_insn_emulator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // Trap emulation predictor
   // ---------------------------------------------------------------
   function automatic logic [20:0] stack_linear(logic [15:0] seg, logic [15:0] offs);
      return {1'b0, seg, 4'h0} + {5'h0, offs};
   endfunction

   function automatic logic [31:0] flags_with_vif(logic [31:0] f);
      return model_vif ? (f | FLAG_IF) : (f & ~FLAG_IF);
   endfunction

   function automatic void expect_side(logic [3:0] kind, logic [20:0] addr, logic [31:0] data);
      rsp_type r = '0;
      r.side_kind = kind;
      r.side_addr = addr;
      r.side_data = data;
      expected_results.push_back(r);
   endfunction

   function automatic void emulate_trap(req_type t);
      rsp_type     fin;
      logic [15:0] ip, cs, sp;
      logic [31:0] flags, acc, word;
      logic [7:0]  opc, vec;
      logic [1:0]  st;
      logic        opsize32;
      int unsigned pos;
      bit          found;
      ip = t.guest_ip;
      cs = t.guest_cs;
      sp = t.guest_sp;
      flags = t.guest_flags;
      acc = t.guest_acc;
      st = ST_RESUME;
      opsize32 = 1'b0;
      opc = '0;
      pos = 0;
      found = 0;

      // prefix scan, each prefix steps ip
      while (pos < 4 && !found) begin
         opc = t.insn_bytes[8*pos +: 8];
         if (opc == OPC_OPSIZE)
            opsize32 = 1'b1;
         else if (opc != OPC_ADSIZE)
            found = 1;
         if (!found) begin
            pos++;
            ip++;
         end
      end

      if (!found) begin
         st = ST_UNHANDLED;
      end else begin
         case (opc)
            OPC_INT: begin
               if (pos >= 3) begin
                  st = ST_UNHANDLED;
               end else begin
                  vec = t.insn_bytes[8*(pos+1) +: 8];
                  if (vec == VEC_EXIT) begin
                     st = ST_EXIT;
                  end else if (vec == VEC_WAIT) begin
                     st = ST_WAIT;
                     ip = ip + 16'd2;
                  end else begin
                     // three 16-bit pushes regardless of operand size
                     sp = sp - 16'd6;
                     word = flags_with_vif(flags);
                     expect_side(SK_MEM16, stack_linear(t.guest_ss, sp), {16'h0, ip + 16'd2});
                     expect_side(SK_MEM16, stack_linear(t.guest_ss, sp + 16'd2), {16'h0, cs});
                     expect_side(SK_MEM16, stack_linear(t.guest_ss, sp + 16'd4),
                                 {16'h0, word[15:0]});
                     ip = t.mem_word0[15:0];
                     cs = t.mem_word0[31:16];
                  end
               end
            end
            OPC_PUSHF: begin
               word = flags_with_vif(flags);
               if (opsize32) begin
                  sp = sp - 16'd4;
                  expect_side(SK_MEM32, stack_linear(t.guest_ss, sp), word);
               end else begin
                  sp = sp - 16'd2;
                  expect_side(SK_MEM16, stack_linear(t.guest_ss, sp), {16'h0, word[15:0]});
               end
               ip++;
            end
            OPC_POPF: begin
               word = opsize32 ? t.mem_word0 : {16'h0, t.mem_word0[15:0]};
               flags = word | FLAG_VM | FLAG_IF;
               model_vif = word[FLAG_IF_BIT];
               sp = sp + (opsize32 ? 16'd4 : 16'd2);
               ip++;
            end
            OPC_OUTB: begin
               expect_side(SK_OUT8, {5'h0, t.guest_port}, {24'h0, acc[7:0]});
               ip++;
            end
            OPC_OUTW: begin
               if (opsize32)
                  expect_side(SK_OUT32, {5'h0, t.guest_port}, acc);
               else
                  expect_side(SK_OUT16, {5'h0, t.guest_port}, {16'h0, acc[15:0]});
               ip++;
            end
            OPC_INB: begin
               expect_side(SK_IN8, {5'h0, t.guest_port}, '0);
               acc[7:0] = t.port_read_data[7:0];
               ip++;
            end
            OPC_INW: begin
               if (opsize32) begin
                  expect_side(SK_IN32, {5'h0, t.guest_port}, '0);
                  acc = t.port_read_data;
               end else begin
                  expect_side(SK_IN16, {5'h0, t.guest_port}, '0);
                  acc[15:0] = t.port_read_data[15:0];
               end
               ip++;
            end
            OPC_IRET: begin
               word = opsize32 ? t.mem_word2 : {16'h0, t.mem_word2[15:0]};
               ip = t.mem_word0[15:0];
               cs = t.mem_word1[15:0];
               flags = word | FLAG_VM | FLAG_IF;
               model_vif = word[FLAG_IF_BIT];
               sp = sp + (opsize32 ? 16'd12 : 16'd6);
            end
            OPC_CLI: begin
               model_vif = 1'b0;
               ip++;
            end
            OPC_STI: begin
               model_vif = 1'b1;
               ip++;
            end
            default: st = ST_UNHANDLED;
         endcase
      end

      fin = '0;
      fin.status = st;
      fin.new_ip = ip;
      fin.new_cs = cs;
      fin.new_sp = sp;
      fin.new_flags = flags;
      fin.new_acc = acc;
      fin.last = 1'b1;
      expected_results.push_back(fin);
   endfunction

   // ---------------------------------------------------------------
   // Request generation
   // ---------------------------------------------------------------
   function automatic req_type random_trap(logic [31:0] insn);
      req_type t;
      t.insn_bytes = insn;
      t.guest_ip = 16'($urandom);
      t.guest_cs = 16'($urandom);
      t.guest_ss = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
      case ($urandom_range(0, 3))
         0: t.guest_sp = 16'($urandom_range(0, 7));
         1: t.guest_sp = 16'hFFFF - 16'($urandom_range(0, 11));
         default: t.guest_sp = 16'($urandom);
      endcase
      t.guest_flags = $urandom;
      t.guest_acc = $urandom;
      t.guest_port = 16'($urandom);
      t.port_read_data = $urandom;
      t.mem_word0 = $urandom;
      t.mem_word1 = $urandom;
      t.mem_word2 = $urandom;
      return t;
   endfunction

   function automatic logic [7:0] pick_opcode();
      case ($urandom_range(0, 9))
         0: return OPC_INT;
         1: return OPC_PUSHF;
         2: return OPC_POPF;
         3: return OPC_OUTB;
         4: return OPC_OUTW;
         5: return OPC_INB;
         6: return OPC_INW;
         7: return OPC_IRET;
         8: return OPC_CLI;
         default: return OPC_STI;
      endcase
   endfunction

   // well-formed instruction: prefixes, opcode, vector byte for int
   function automatic logic [31:0] build_insn();
      logic [31:0] b;
      logic [7:0]  opc;
      int unsigned npfx;
      int unsigned sel;
      b = $urandom;
      sel = $urandom_range(0, 9);
      npfx = (sel < 5) ? 0 : (sel < 8) ? 1 : (sel == 8) ? 2 : 3;
      opc = pick_opcode();
      for (int i = 0; i < npfx; i++)
         b[8*i +: 8] = $urandom_range(0, 1) ? OPC_OPSIZE : OPC_ADSIZE;
      b[8*npfx +: 8] = opc;
      if (opc == OPC_INT && npfx < 3) begin
         case ($urandom_range(0, 4))
            0: b[8*(npfx+1) +: 8] = VEC_EXIT;
            1: b[8*(npfx+1) +: 8] = VEC_WAIT;
            default: ;
         endcase
      end
      return b;
   endfunction

   function automatic void queue_trap(req_type t, bit wait_idle);
      queued_trap_type q;
      q.req = t;
      q.wait_idle = wait_idle;
      pending_traps.push_back(q);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : drive
      queued_trap_type nxt;
      bit              take;
      bit              slot_free;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         take = 0;
         slot_free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            emulate_trap(req_payload);
            traps_sent++;
         end
         if (slot_free) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_traps.size() != 0 &&
                     !(pending_traps[0].wait_idle && expected_results.size() != 0))
               take = 1;
         end
         if (take) begin
            nxt = pending_traps.pop_front();
            req_payload <= nxt.req;
            req_valid <= 1'b1;
            if (burst_left == 0)
               burst_left = $urandom_range(1, 30);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else if (slot_free) begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result back-pressure: ready pattern drawn at random from four modes
   // ---------------------------------------------------------------
   ready_mode_type ready_mode;
   int             mode_left;
   int unsigned    ready_tick;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
         ready_tick = 0;
         ready_mode = RDY_ALWAYS;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         ready_tick++;
         case (ready_mode)
            RDY_ALWAYS:           rsp_ready <= 1'b1;
            RDY_COIN:             rsp_ready <= $urandom_range(0, 1);
            RDY_EVERY_FOURTH_LOW: rsp_ready <= (ready_tick % 4) != 0;
            default:              rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_payload);
         end else begin
            want = expected_results.pop_front();
            check_field("status",    want.status,    rsp_payload.status);
            check_field("side_kind", want.side_kind, rsp_payload.side_kind);
            check_field("side_addr", want.side_addr, rsp_payload.side_addr);
            check_field("side_data", want.side_data, rsp_payload.side_data);
            check_field("new_ip",    want.new_ip,    rsp_payload.new_ip);
            check_field("new_cs",    want.new_cs,    rsp_payload.new_cs);
            check_field("new_sp",    want.new_sp,    rsp_payload.new_sp);
            check_field("new_flags", want.new_flags, rsp_payload.new_flags);
            check_field("new_acc",   want.new_acc,   rsp_payload.new_acc);
            check_field("last",      want.last,      rsp_payload.last);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      req_type t;
      model_vif = 1'b0;
      traps_sent = 0;
      error_count = 0;

      // pushf with virtual IF clear, all flags set, stack wraps below zero
      t = random_trap(32'h0000_009C);
      t.guest_flags = '1; t.guest_ss = 16'hFFFF; t.guest_sp = 16'h0000;
      queue_trap(t, 0);
      // sti
      queue_trap(random_trap(32'h0000_00FB), 0);
      // 32-bit pushf, flags clear, wrap
      t = random_trap(32'h0000_9C66);
      t.guest_flags = '0; t.guest_sp = 16'h0002;
      queue_trap(t, 0);
      // int n with virtual IF set, wrapping stack
      t = random_trap(32'h0000_21CD);
      t.guest_flags = '0; t.guest_sp = 16'h0004; t.guest_ss = 16'hFFFF;
      queue_trap(t, 0);
      // cli
      queue_trap(random_trap(32'h0000_00FA), 0);
      // int n behind both prefixes, virtual IF clear
      t = random_trap(32'h10CD_6766);
      t.guest_flags = '1;
      queue_trap(t, 0);
      // int 3 ends the task
      queue_trap(random_trap(32'h0000_03CD), 0);
      // int 0xFC waits, ip wraps
      t = random_trap(32'h0000_FCCD);
      t.guest_ip = 16'hFFFF;
      queue_trap(t, 0);
      // 16-bit popf, IF set in popped word
      t = random_trap(32'h0000_009D);
      t.mem_word0 = '1; t.guest_sp = 16'hFFFE;
      queue_trap(t, 0);
      // pushf sees the popped IF
      queue_trap(random_trap(32'h0000_009C), 0);
      // 32-bit popf of zero clears virtual IF
      t = random_trap(32'h0000_9D66);
      t.mem_word0 = '0; t.guest_sp = 16'hFFFC;
      queue_trap(t, 0);
      // 16-bit iret with IF set
      t = random_trap(32'h0000_00CF);
      t.mem_word2 = t.mem_word2 | FLAG_IF; t.guest_sp = 16'hFFFA;
      queue_trap(t, 0);
      // 32-bit iret, all ones
      t = random_trap(32'h0000_CF66);
      t.mem_word2 = '1; t.guest_sp = 16'hFFF8;
      queue_trap(t, 0);
      // out 8/16/32, the first two with extreme port and data
      t = random_trap(32'h0000_00EE);
      t.guest_acc = '1; t.guest_port = 16'hFFFF;
      queue_trap(t, 0);
      t = random_trap(32'h0000_00EF);
      t.guest_acc = '1; t.guest_port = 16'h0000;
      queue_trap(t, 0);
      queue_trap(random_trap(32'h0000_EF66), 0);
      // in 8/16/32
      t = random_trap(32'h0000_00EC);
      t.guest_acc = '0; t.port_read_data = '1;
      queue_trap(t, 0);
      t = random_trap(32'h0000_00ED);
      t.guest_acc = '1; t.port_read_data = '0;
      queue_trap(t, 0);
      queue_trap(random_trap(32'h0000_ED66), 0);
      // all four bytes are prefixes
      queue_trap(random_trap(32'h6766_6766), 0);
      // int opcode in the last byte, vector missing
      queue_trap(random_trap(32'hCD67_6766), 0);
      // sti as the fourth byte
      queue_trap(random_trap(32'hFB66_6666), 0);
      // opcode not emulated
      queue_trap(random_trap(32'h0000_0090), 0);
      // all fields at zero and at all ones
      queue_trap('0, 0);
      queue_trap('1, 0);

      // random part: mostly well-formed, some raw noise, two pauses to drain
      for (int i = 0; i < 195; i++) begin
         if ($urandom_range(0, 6) == 0)
            t = random_trap($urandom);
         else
            t = random_trap(build_insn());
         queue_trap(t, (i == 0) || (i == 98));
      end
      traps_total = pending_traps.size();

      while (traps_sent < traps_total) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
